>>> rtl/core/mks_pkg.sv
package mks_pkg;

  localparam logic [3:0] DOT_UNITS            = 4'd1;
  localparam logic [3:0] DASH_UNITS           = 4'd3;
  localparam logic [3:0] ELEMENT_GAP_UNITS    = 4'd1;
  localparam logic [3:0] CHAR_GAP_RESET       = 4'd2;
  localparam logic [3:0] WORD_GAP_RESET       = 4'd4;

  localparam logic REG_CHAR_GAP = 1'b0;
  localparam logic REG_WORD_GAP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHAR_GAP,
    ST_MARK,
    ST_SPACE,
    ST_WORD_GAP
  } mks_state_t;

  typedef enum logic [1:0] {
    SEG_CHAR_GAP,
    SEG_MARK,
    SEG_SPACE,
    SEG_WORD_GAP
  } mks_seg_t;

  typedef struct packed {
    logic     in_ready;
    logic     capture;
    logic     emit;
    mks_seg_t seg;
    logic     last;
    logic     advance;
  } mks_cmd_t;

  typedef struct packed {
    logic out_free;
    logic no_elements;
    logic final_element;
    logic end_of_word;
  } mks_status_t;

  typedef struct packed {
    logic [2:0] count;
    logic [7:0] pattern;
  } mks_code_t;

  // Element pattern: bit 0 is sent first, 1 is a dash and 0 a dot.
  function automatic mks_code_t code_lookup(input logic [7:0] c);
    mks_code_t r;
    case (c)
      8'h41: r = '{3'd2, 8'd2};   // A
      8'h42: r = '{3'd4, 8'd1};
      8'h43: r = '{3'd4, 8'd5};
      8'h44: r = '{3'd3, 8'd1};
      8'h45: r = '{3'd1, 8'd0};
      8'h46: r = '{3'd4, 8'd4};
      8'h47: r = '{3'd3, 8'd3};
      8'h48: r = '{3'd4, 8'd0};
      8'h49: r = '{3'd2, 8'd0};
      8'h4A: r = '{3'd4, 8'd14};
      8'h4B: r = '{3'd3, 8'd5};
      8'h4C: r = '{3'd4, 8'd2};
      8'h4D: r = '{3'd2, 8'd3};
      8'h4E: r = '{3'd2, 8'd1};
      8'h4F: r = '{3'd3, 8'd7};
      8'h50: r = '{3'd4, 8'd6};
      8'h51: r = '{3'd4, 8'd11};
      8'h52: r = '{3'd3, 8'd2};
      8'h53: r = '{3'd3, 8'd0};
      8'h54: r = '{3'd1, 8'd1};
      8'h55: r = '{3'd3, 8'd4};
      8'h56: r = '{3'd4, 8'd8};
      8'h57: r = '{3'd3, 8'd6};
      8'h58: r = '{3'd4, 8'd9};
      8'h59: r = '{3'd4, 8'd13};
      8'h5A: r = '{3'd4, 8'd3};   // Z
      8'h31: r = '{3'd5, 8'd30};  // 1
      8'h32: r = '{3'd5, 8'd28};
      8'h33: r = '{3'd5, 8'd24};
      8'h34: r = '{3'd5, 8'd16};
      8'h35: r = '{3'd5, 8'd0};
      8'h36: r = '{3'd5, 8'd1};
      8'h37: r = '{3'd5, 8'd3};
      8'h38: r = '{3'd5, 8'd7};
      8'h39: r = '{3'd5, 8'd15};
      8'h30: r = '{3'd5, 8'd31};  // 0
      8'h2E: r = '{3'd6, 8'd42};  // full stop
      8'h2D: r = '{3'd6, 8'd33};  // hyphen
      8'h2C: r = '{3'd6, 8'd51};  // comma
      8'h2B: r = '{3'd5, 8'd10};  // plus
      8'h21: r = '{3'd6, 8'd53};  // exclamation mark
      8'h24: r = '{3'd7, 8'd72};  // dollar sign
      default: r = '{3'd0, 8'd0};
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/mks_if.sv
interface mks_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_word;

  modport source (output valid, output char_code, output end_of_word, input ready);
  modport sink   (input valid, input char_code, input end_of_word, output ready);
endinterface

interface mks_out_if;
  logic       valid;
  logic       ready;
  logic       key_on;
  logic [3:0] duration_units;
  logic       last;

  modport source (output valid, output key_on, output duration_units, output last,
                  input ready);
  modport sink   (input valid, input key_on, input duration_units, input last,
                  output ready);
endinterface

>>> rtl/core/mks_ctrl.sv
module mks_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  mks_pkg::mks_status_t status,
  output mks_pkg::mks_cmd_t    cmd
);
  import mks_pkg::*;

  mks_state_t state;
  mks_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHAR_GAP;
      end
      ST_CHAR_GAP: begin
        if (status.out_free) begin
          if (!status.no_elements) state_next = ST_MARK;
          else if (status.end_of_word) state_next = ST_WORD_GAP;
          else state_next = ST_IDLE;
        end
      end
      ST_MARK: begin
        if (status.out_free) state_next = ST_SPACE;
      end
      ST_SPACE: begin
        if (status.out_free) begin
          if (!status.final_element) state_next = ST_MARK;
          else if (status.end_of_word) state_next = ST_WORD_GAP;
          else state_next = ST_IDLE;
        end
      end
      ST_WORD_GAP: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{in_ready: 1'b0, capture: 1'b0, emit: 1'b0, seg: SEG_CHAR_GAP,
            last: 1'b0, advance: 1'b0};
    case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.capture  = in_valid;
      end
      ST_CHAR_GAP: begin
        cmd.emit = status.out_free;
        cmd.seg  = SEG_CHAR_GAP;
        cmd.last = status.no_elements && !status.end_of_word;
      end
      ST_MARK: begin
        cmd.emit = status.out_free;
        cmd.seg  = SEG_MARK;
      end
      ST_SPACE: begin
        cmd.emit    = status.out_free;
        cmd.seg     = SEG_SPACE;
        cmd.last    = status.final_element && !status.end_of_word;
        cmd.advance = status.out_free;
      end
      ST_WORD_GAP: begin
        cmd.emit = status.out_free;
        cmd.seg  = SEG_WORD_GAP;
        cmd.last = 1'b1;
      end
      default: begin
        cmd.in_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/core/mks_datapath.sv
module mks_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           char_code,
  input  logic                 end_of_word,
  input  mks_pkg::mks_cmd_t    cmd,
  output mks_pkg::mks_status_t status,
  mks_out_if.source            out_ch,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata
);
  import mks_pkg::*;

  logic [3:0] char_gap;
  logic [3:0] word_gap;
  logic [7:0] pattern;
  logic [2:0] count;
  logic       eow;
  logic [2:0] idx;
  logic       out_valid;
  logic       out_key_on;
  logic [3:0] out_dur;
  logic       out_last;
  mks_code_t  code;
  logic       seg_key;
  logic [3:0] seg_dur;

  assign code = code_lookup(char_code);

  // Only bit 2 of the address selects a register; the low bits are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_gap <= CHAR_GAP_RESET;
      word_gap <= WORD_GAP_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_CHAR_GAP) char_gap <= pwdata[3:0];
      else word_gap <= pwdata[3:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_CHAR_GAP) prdata = {28'd0, char_gap};
    else prdata = {28'd0, word_gap};
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pattern <= code.pattern;
      count   <= code.count;
      eow     <= end_of_word;
      idx     <= 3'd0;
    end else if (cmd.advance) begin
      idx <= idx + 3'd1;
    end
  end

  always_comb begin
    case (cmd.seg)
      SEG_CHAR_GAP: begin
        seg_key = 1'b0;
        seg_dur = char_gap;
      end
      SEG_MARK: begin
        seg_key = 1'b1;
        seg_dur = pattern[idx] ? DASH_UNITS : DOT_UNITS;
      end
      SEG_SPACE: begin
        seg_key = 1'b0;
        seg_dur = ELEMENT_GAP_UNITS;
      end
      SEG_WORD_GAP: begin
        seg_key = 1'b0;
        seg_dur = word_gap;
      end
      default: begin
        seg_key = 1'b0;
        seg_dur = 4'd0;
      end
    endcase
  end

  // Hold the word until taken; load the next one in the same cycle it leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_key_on <= seg_key;
      out_dur    <= seg_dur;
      out_last   <= cmd.last;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.key_on         = out_key_on;
  assign out_ch.duration_units = out_dur;
  assign out_ch.last           = out_last;

  assign status.out_free      = !out_valid || out_ch.ready;
  assign status.no_elements   = (count == 3'd0);
  assign status.final_element = (({1'b0, idx} + 4'd1) == {1'b0, count});
  assign status.end_of_word   = eow;

endmodule

>>> rtl/core/morse_keying_sequencer.sv
// Morse keying sequencer.
// in_ch takes one word per character: char_code (ASCII) and end_of_word.
// out_ch gives one word per keying segment: key_on, duration_units in dot
// units, and last on the final segment of the character. A character gives a
// character gap, then a mark (1 or 3 units) and a 1-unit space per element,
// then a word gap if end_of_word is set: 1 to 16 segments in all.
// in_ch is ready only between characters. After a character is taken the
// controller's character-gap state loads the first segment into the output
// register, and one segment follows each cycle while out_ch is ready.
// When out_ch stalls the output register holds its word and the controller
// waits; nothing is dropped. The next character may be taken while the last
// segment of the previous one still waits in the output register.
// Registers on the APB port: char_gap_units at 0x0, word_gap_units at 0x4.
// Synchronous reset sets them to 2 and 4 and empties the output register.
module morse_keying_sequencer (
  input  logic        clk,
  input  logic        rst,
  mks_in_if.sink      in_ch,
  mks_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mks_pkg::*;

  mks_cmd_t    cmd;
  mks_status_t status;

  assign pready      = 1'b1;
  assign in_ch.ready = cmd.in_ready;

  mks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .status   (status),
    .cmd      (cmd)
  );

  mks_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .char_code   (in_ch.char_code),
    .end_of_word (in_ch.end_of_word),
    .cmd         (cmd),
    .status      (status),
    .out_ch      (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
  );

endmodule

>>> sim/testbench.sv
module testbench;
  import mks_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES        = 6;
  localparam int PHASE_CHARS   = 75;

  typedef struct packed {
    logic       key_on;
    logic [3:0] dur;
    logic       last;
  } key_seg_t;

  typedef struct packed {
    logic [7:0]     ch;
    logic           eow;
    logic [3:0]     cg;
    logic [3:0]     wg;
    logic [2:0]     n;
    key_seg_t [3:0] typed;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mks_in_if  in_ch ();
  mks_out_if out_ch ();

  morse_keying_sequencer u_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  key_seg_t    segs_due [$];
  logic [3:0]  char_gap_cur;
  logic [3:0]  word_gap_cur;
  plan_row_t   plan [24];
  string       alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.-,+!$";
  bit          steady;
  int          stall_ask;
  int          fails;
  int          chars_sent;
  int          unknown_sent;
  int          words_closed;
  int          segs_seen;
  int          settings_used;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic string morse_of(input logic [7:0] ch);
    case (ch)
      "A": return ".-";
      "B": return "-...";
      "C": return "-.-.";
      "D": return "-..";
      "E": return ".";
      "F": return "..-.";
      "G": return "--.";
      "H": return "....";
      "I": return "..";
      "J": return ".---";
      "K": return "-.-";
      "L": return ".-..";
      "M": return "--";
      "N": return "-.";
      "O": return "---";
      "P": return ".--.";
      "Q": return "--.-";
      "R": return ".-.";
      "S": return "...";
      "T": return "-";
      "U": return "..-";
      "V": return "...-";
      "W": return ".--";
      "X": return "-..-";
      "Y": return "-.--";
      "Z": return "--..";
      "1": return ".----";
      "2": return "..---";
      "3": return "...--";
      "4": return "....-";
      "5": return ".....";
      "6": return "-....";
      "7": return "--...";
      "8": return "---..";
      "9": return "----.";
      "0": return "-----";
      ".": return ".-.-.-";
      "-": return "-....-";
      ",": return "--..--";
      "+": return ".-.-.";
      "!": return "-.-.--";
      "$": return "...-..-";
      default: return "";
    endcase
  endfunction

  // Gap first, then mark and space per element, then the word gap if asked.
  function automatic void forecast_segments(input logic [7:0] ch, input logic eow);
    string code;
    int    total;
    int    k;
    code  = morse_of(ch);
    total = 1 + 2 * code.len() + int'(eow);
    segs_due.push_back('{1'b0, char_gap_cur, total == 1});
    for (k = 0; k < code.len(); k++) begin
      segs_due.push_back('{1'b1, (code[k] == "-") ? DASH_UNITS : DOT_UNITS, 1'b0});
      segs_due.push_back('{1'b0, ELEMENT_GAP_UNITS, !eow && (k == code.len() - 1)});
    end
    if (eow) segs_due.push_back('{1'b0, word_gap_cur, 1'b1});
  endfunction

  function automatic key_seg_t sg(input logic k, input logic [3:0] d, input logic l);
    return '{k, d, l};
  endfunction

  function automatic plan_row_t mk(input logic [7:0] ch, input logic eow,
                                   input logic [3:0] cg, input logic [3:0] wg,
                                   input int n = 0,
                                   input key_seg_t a = '0, input key_seg_t b = '0,
                                   input key_seg_t c = '0, input key_seg_t d = '0);
    plan_row_t r;
    r.ch       = ch;
    r.eow      = eow;
    r.cg       = cg;
    r.wg       = wg;
    r.n        = 3'(n);
    r.typed[0] = a;
    r.typed[1] = b;
    r.typed[2] = c;
    r.typed[3] = d;
    return r;
  endfunction

  task automatic offer_char(input logic [7:0] ch, input logic eow);
    if (!steady) begin
      while ($urandom_range(99) < 38) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid       <= 1'b1;
    in_ch.char_code   <= ch;
    in_ch.end_of_word <= eow;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    chars_sent++;
    if (morse_of(ch).len() == 0) unknown_sent++;
    if (eow) words_closed++;
  endtask

  // Drop valid and wait until every segment has come out.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (segs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gap(input logic idx, input logic [3:0] units);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom() & 32'hFFFF_FFF0) | units;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_CHAR_GAP) char_gap_cur = units;
    else word_gap_cur = units;
    @(posedge clk);
  endtask

  task automatic set_gaps(input logic [3:0] cg, input logic [3:0] wg);
    settle();
    write_gap(REG_CHAR_GAP, cg);
    write_gap(REG_WORD_GAP, wg);
    settings_used++;
  endtask

  initial begin : sink_side
    key_seg_t want;
    int       hold;
    int       stall_seen;
    hold       = 0;
    stall_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        segs_seen++;
        if (segs_due.size() == 0) begin
          $error("unexpected word: key_on=%0b duration_units=%0d last=%0b",
                 out_ch.key_on, out_ch.duration_units, out_ch.last);
          fails++;
        end else begin
          want = segs_due.pop_front();
          if (out_ch.key_on !== want.key_on) begin
            $error("key_on: expected %0b, got %0b", want.key_on, out_ch.key_on);
            fails++;
          end
          if (out_ch.duration_units !== want.dur) begin
            $error("duration_units: expected %0d, got %0d", want.dur, out_ch.duration_units);
            fails++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_ch.last);
            fails++;
          end
        end
      end
      if (stall_ask != stall_seen) begin
        stall_seen = stall_ask;
        hold       = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 38);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    plan_row_t  r;
    int         i;
    int         k;
    int         p;
    int         j;
    logic [7:0] ch;
    logic       eow;

    rst               <= 1'b1;
    in_ch.valid       <= 1'b0;
    in_ch.char_code   <= '0;
    in_ch.end_of_word <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    char_gap_cur  = CHAR_GAP_RESET;
    word_gap_cur  = WORD_GAP_RESET;
    steady        = 1'b0;
    stall_ask     = 0;
    fails         = 0;
    chars_sent    = 0;
    unknown_sent  = 0;
    words_closed  = 0;
    segs_seen     = 0;
    settings_used = 1;

    // Rows with n set carry their segments; the rest go through the predictor.
    plan = '{
      mk(8'h00, 0, 2, 4, 1, sg(0, 2, 1)),
      mk(8'hFF, 1, 2, 4, 2, sg(0, 2, 0), sg(0, 4, 1)),
      mk("E",   1, 2, 4, 4, sg(0, 2, 0), sg(1, 1, 0), sg(0, 1, 0), sg(0, 4, 1)),
      mk("T",   0, 2, 4, 3, sg(0, 2, 0), sg(1, 3, 0), sg(0, 1, 1)),
      mk("$",   1, 2, 4),
      mk("a",   0, 2, 4),
      mk("0",   1, 2, 4),
      mk("9",   0, 2, 4),
      mk("A",   0, 2, 4),
      mk("Z",   1, 2, 4),
      mk(".",   0, 2, 4),
      mk("-",   1, 2, 4),
      mk(",",   0, 2, 4),
      mk("+",   1, 2, 4),
      mk("!",   0, 2, 4),
      mk(8'h00, 1, 0, 0, 2, sg(0, 0, 0), sg(0, 0, 1)),
      mk("E",   0, 0, 0, 3, sg(0, 0, 0), sg(1, 1, 0), sg(0, 1, 1)),
      mk("$",   1, 0, 0),
      mk(8'hFF, 1, 15, 15, 2, sg(0, 15, 0), sg(0, 15, 1)),
      mk("$",   1, 15, 15),
      mk("0",   0, 15, 15),
      mk("5",   1, 15, 0),
      mk(8'h80, 0, 0, 15, 1, sg(0, 0, 1)),
      mk(" ",   1, 0, 15, 2, sg(0, 0, 0), sg(0, 15, 1))
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < $size(plan); i++) begin
      r = plan[i];
      if (r.cg != char_gap_cur || r.wg != word_gap_cur) set_gaps(r.cg, r.wg);
      offer_char(r.ch, r.eow);
      if (r.n != 0) begin
        for (k = 0; k < r.n; k++) segs_due.push_back(r.typed[k]);
      end else begin
        forecast_segments(r.ch, r.eow);
      end
    end

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: set_gaps(4'd0, 4'd15);
        1: set_gaps(4'd15, 4'd0);
        default: set_gaps(4'($urandom_range(15)), 4'($urandom_range(15)));
      endcase
      for (j = 0; j < PHASE_CHARS; j++) begin
        if (p == 2 && j == 10) stall_ask++;
        if (p == 3) steady = (j < 60);
        if (p == 4 && j == 40) settle();
        if ($urandom_range(99) < 80) ch = alphabet[$urandom_range(alphabet.len() - 1)];
        else ch = 8'($urandom_range(255));
        eow = ($urandom_range(99) < 30);
        offer_char(ch, eow);
        forecast_segments(ch, eow);
      end
    end
    steady = 1'b0;

    settle();
    if (segs_due.size() != 0) begin
      $error("%0d keying segments never arrived", segs_due.size());
      fails += segs_due.size();
    end

    $display("Sent %0d characters (%0d outside the code table, %0d closing a word), %0d segments",
             chars_sent, unknown_sent, words_closed, segs_seen);
    $display("Covered %0d gap settings incl. 0 and 15, random stalls and a %0d-cycle output hold",
             settings_used, HOLD_CYCLES);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
